/* rtl/ctwa_pkg.sv */
package ctwa_pkg;
  localparam int ENTRIES = 64;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int ENTRY_W = 4 * 64 + 32 + 8;

  localparam logic [1:0] OP_SHOW = 2'd0;
  localparam logic [1:0] OP_AGE = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [2:0] ST_OUT_OF_RANGE = 3'd0;
  localparam logic [2:0] ST_REFRESHED = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_AGED = 3'd4;
  localparam logic [2:0] ST_PEEK_OK = 3'd5;
  localparam logic [2:0] ST_PEEK_PAST = 3'd6;

  localparam logic [1:0] REG_PORT_LOW = 2'd0;
  localparam logic [1:0] REG_PORT_HIGH = 2'd1;
  localparam logic [1:0] REG_START_AGE = 2'd2;
  localparam logic [1:0] REG_MAX_ENTRIES = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [63:0] local_addr_hi;
    logic [63:0] local_addr_lo;
    logic [63:0] remote_addr_hi;
    logic [63:0] remote_addr_lo;
    logic [15:0] lport;
    logic [15:0] rport;
    logic [5:0] entry_index;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] entry_count;
    logic [63:0] out_local_addr_hi;
    logic [63:0] out_local_addr_lo;
    logic [63:0] out_remote_addr_hi;
    logic [63:0] out_remote_addr_lo;
    logic [15:0] out_lport;
    logic [15:0] out_rport;
  } rsp_t;

  typedef struct packed {
    logic [1:0] index;
    logic [15:0] data;
  } cfg_t;

  typedef struct packed {
    logic [63:0] lhi;
    logic [63:0] llo;
    logic [63:0] rhi;
    logic [63:0] rlo;
    logic [31:0] ports;
    logic [7:0] age;
  } entry_t;
endpackage

/* rtl/ctwa_if.sv */
interface ctwa_if #(type T = logic);
  logic valid;
  logic ready;
  T payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/connection_table_with_aging_core.sv */
// Connection table of up to 64 entries held in one RAM in insertion order. One
// transaction is worked at a time: a show scans the held entries one per cycle,
// refreshes the age of a hit and stops there, else inserts the entry if below the
// limit (an out-of-range local port is answered without a scan); an age tick reads
// and compacts one slot per cycle; a peek reads the given slot. The result waits in
// the output register and the next transaction can be taken in the cycle after it
// leaves. Config writes are accepted any time but belong between transactions.
module connection_table_with_aging_core (
  input logic clk,
  input logic rst,
  ctwa_if.sink   in_ch,
  ctwa_if.source out_ch,
  ctwa_if.sink   cfg_ch
);
  import ctwa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_AGE = 3'd3;
  localparam logic [2:0] S_PEEK = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [15:0] port_low, port_high;
  logic [7:0] start_age;
  logic [6:0] max_ent;
  logic [2:0] state;
  req_t req;
  logic [CNT_W-1:0] count, rd_ptr, kept;
  logic rd_pend;
  logic [IDX_W-1:0] rd_slot;
  logic we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t wdata, rdata;
  rsp_t rsp;
  logic out_valid;
  logic [31:0] ports;
  logic key_hit;
  logic [CNT_W-1:0] limit;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.payload = rsp;
  assign ports = {req.lport, req.rport};
  assign key_hit = rdata.lhi == req.local_addr_hi && rdata.llo == req.local_addr_lo &&
                   rdata.rhi == req.remote_addr_hi && rdata.rlo == req.remote_addr_lo &&
                   rdata.ports == ports;
  assign limit = (max_ent > 7'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(max_ent);
  assign raddr = (state == S_IDLE) ? in_ch.payload.entry_index[IDX_W-1:0]
                                   : rd_ptr[IDX_W-1:0];

  ctwa_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      port_low <= '0;
      port_high <= 16'hFFFF;
      start_age <= 8'd1;
      max_ent <= 7'd64;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.payload.index)
        REG_PORT_LOW: port_low <= cfg_ch.payload.data;
        REG_PORT_HIGH: port_high <= cfg_ch.payload.data;
        REG_START_AGE: start_age <= cfg_ch.payload.data[7:0];
        REG_MAX_ENTRIES: max_ent <= cfg_ch.payload.data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      rd_ptr <= '0;
      kept <= '0;
      rd_pend <= 1'b0;
      we <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          req <= in_ch.payload;
          rsp <= '{status: ST_OUT_OF_RANGE, entry_count: 7'(count), default: '0};
          rd_ptr <= '0;
          kept <= '0;
          rd_pend <= 1'b0;
          unique case (in_ch.payload.opcode)
            OP_SHOW: begin
              if (in_ch.payload.lport < port_low ||
                  in_ch.payload.lport > port_high) begin
                state <= S_DONE;
              end else state <= S_SCAN;
            end
            OP_AGE: state <= S_AGE;
            OP_PEEK: state <= S_PEEK;
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_SCAN: begin
          if (rd_pend && key_hit) begin
            we <= 1'b1;
            waddr <= rd_slot;
            wdata <= {rdata.lhi, rdata.llo, rdata.rhi, rdata.rlo, rdata.ports, start_age};
            rsp.status <= ST_REFRESHED;
            state <= S_DONE;
          end else if (rd_ptr < count) begin
            we <= 1'b0;
            rd_pend <= 1'b1;
            rd_slot <= rd_ptr[IDX_W-1:0];
            rd_ptr <= rd_ptr + 1'b1;
          end else begin
            we <= 1'b0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (count < limit) begin
            we <= 1'b1;
            waddr <= count[IDX_W-1:0];
            wdata <= {req.local_addr_hi, req.local_addr_lo, req.remote_addr_hi,
                      req.remote_addr_lo, ports, start_age};
            count <= count + 1'b1;
            rsp.entry_count <= 7'(count + 1'b1);
            rsp.status <= ST_INSERTED;
          end else begin
            we <= 1'b0;
            rsp.status <= ST_FULL;
          end
          state <= S_DONE;
        end
        S_AGE: begin
          if (rd_pend && rdata.age != 8'd0) begin
            we <= 1'b1;
            waddr <= kept[IDX_W-1:0];
            wdata <= {rdata.lhi, rdata.llo, rdata.rhi, rdata.rlo, rdata.ports,
                      rdata.age - 8'd1};
            kept <= kept + 1'b1;
          end else we <= 1'b0;
          if (rd_ptr < count) begin
            rd_pend <= 1'b1;
            rd_ptr <= rd_ptr + 1'b1;
          end else begin
            count <= (rd_pend && rdata.age != 8'd0) ? kept + 1'b1 : kept;
            rsp.entry_count <= 7'((rd_pend && rdata.age != 8'd0) ? kept + 1'b1 : kept);
            rsp.status <= ST_AGED;
            state <= S_DONE;
          end
        end
        S_PEEK: begin
          if (CNT_W'(req.entry_index) < count) begin
            rsp.status <= ST_PEEK_OK;
            rsp.out_local_addr_hi <= rdata.lhi;
            rsp.out_local_addr_lo <= rdata.llo;
            rsp.out_remote_addr_hi <= rdata.rhi;
            rsp.out_remote_addr_lo <= rdata.rlo;
            rsp.out_lport <= rdata.ports[31:16];
            rsp.out_rport <= rdata.ports[15:0];
          end else rsp.status <= ST_PEEK_PAST;
          state <= S_DONE;
        end
        S_DONE: begin
          we <= 1'b0;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          we <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

/* rtl/ctwa_ram.sv */
module ctwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
